[rtl/core/rsi_pkg.sv]
// Shared constants and types for the ray/sphere intersection core.
`default_nettype none
package rsi_pkg;

   // Default coordinate width (signed fixed point).
   localparam int COORD_WIDTH_DEFAULT = 32;

   // Radius after reset: 1.0 in Q16.16.
   localparam int RADIUS_RESET = 65536;

   // Limb width of the pipelined multiplier and its register depth.
   localparam int MUL_LIMB = 32;
   localparam int MUL_LAT  = 5;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

endpackage
`default_nettype wire

[rtl/core/rsi_delay.sv]
// Enable-gated delay line that carries valid bits and payload alongside a unit.
`default_nettype none
module rsi_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] line_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];
endmodule
`default_nettype wire

[rtl/core/rsi_mul.sv]
// Pipelined signed multiplier built from registered limb partial products.
`default_nettype none
module rsi_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [AW-1:0] a,
   input  wire logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0]   p
);
   import rsi_pkg::*;

   localparam int L   = MUL_LIMB;
   localparam int NA  = (AW + L - 1) / L;
   localparam int NB  = (BW + L - 1) / L;
   localparam int TW  = (NA + NB) * L;
   localparam int PW  = AW + BW;
   localparam int RWW = (NB + 1) * L;

   logic [AW-1:0]     abs_a;
   logic [BW-1:0]     abs_b;
   logic [NA*L-1:0]   ma_ff;
   logic [NB*L-1:0]   mb_ff;
   logic [3:0]        neg_ff;
   logic [2*L-1:0]    pp_in  [NA][NB];
   logic [2*L-1:0]    pp_ff  [NA][NB];
   logic [RWW-1:0]    row_in [NA];
   logic [RWW-1:0]    row_ff [NA];
   logic [TW-1:0]     tot_in;
   logic [TW-1:0]     tot_ff;
   logic [PW-1:0]     mag;
   logic [PW-1:0]     p_in;
   logic [PW-1:0]     p_ff;

   // Split into sign and magnitude.
   assign abs_a = a[AW-1] ? (~a + 1'b1) : a;
   assign abs_b = b[BW-1] ? (~b + 1'b1) : b;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = ma_ff[i*L +: L] * mb_ff[j*L +: L];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RWW'(pp_ff[i][j]) << (j*L));
         end
      end
   end

   always_comb begin
      tot_in = '0;
      for (int i = 0; i < NA; i++) begin
         tot_in = tot_in + (TW'(row_ff[i]) << (i*L));
      end
   end

   assign mag  = tot_ff[PW-1:0];
   assign p_in = neg_ff[3] ? (~mag + 1'b1) : mag;

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff  <= (NA*L)'(abs_a);
         mb_ff  <= (NB*L)'(abs_b);
         neg_ff <= {neg_ff[2:0], a[AW-1] ^ b[BW-1]};
         pp_ff  <= pp_in;
         row_ff <= row_in;
         tot_ff <= tot_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

[rtl/core/rsi_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module rsi_sqrt #(
   parameter int XW = 130
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [XW-1:0]        rad,
   output logic      [(XW+1)/2-1:0]  root
);
   localparam int RW = (XW + 1) / 2;
   localparam int XE = 2 * RW;

   logic [XE-1:0] rad_q  [0:RW-1];
   logic [XE-1:0] res_q  [0:RW];
   logic [XE-1:0] rad_ff [0:RW-2];
   logic [XE-1:0] res_ff [0:RW-1];

   assign rad_q[0] = XE'(rad);
   assign res_q[0] = '0;

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam int K = RW - 1 - i;
      logic [XE-1:0] bitv;
      logic [XE-1:0] trial;
      logic          take;

      assign bitv  = XE'(1) << (2*K);
      assign trial = res_q[i] + bitv;
      assign take  = rad_q[i] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[i] <= take ? ((res_q[i] >> 1) + bitv) : (res_q[i] >> 1);
         end
      end
      assign res_q[i+1] = res_ff[i];

      // The last stage needs no remainder.
      if (i < RW - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[i] <= take ? (rad_q[i] - trial) : rad_q[i];
            end
         end
         assign rad_q[i+1] = rad_ff[i];
      end
   end

   assign root = res_q[RW][RW-1:0];
endmodule
`default_nettype wire

[rtl/core/rsi_div.sv]
// Pipelined floor division of a signed numerator by a positive divisor.
`default_nettype none
module rsi_div #(
   parameter int NW = 100,
   parameter int MW = 65,
   parameter int QB = 34
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [NW-1:0] num,
   input  wire logic [MW-1:0]        den,
   output logic signed [QB:0]        quo
);
   localparam int RD = (NW > MW + QB) ? NW : MW + QB;

   logic [NW-1:0] mag;
   logic [RD-1:0] rem_q  [0:QB];
   logic [MW-1:0] den_q  [0:QB-1];
   logic [QB-1:0] q_q    [0:QB];
   logic          neg_q  [0:QB];
   logic [RD-1:0] rem_ff [0:QB];
   logic [MW-1:0] den_ff [0:QB-1];
   logic [QB-1:0] q_ff   [1:QB];
   logic          neg_ff [0:QB];
   logic          rem_nz;
   logic [QB:0]   qx;
   logic [QB:0]   quo_ff;

   assign mag = num[NW-1] ? (~num + 1'b1) : num;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RD'(mag);
         den_ff[0] <= den;
         neg_ff[0] <= num[NW-1];
      end
   end
   assign rem_q[0] = rem_ff[0];
   assign den_q[0] = den_ff[0];
   assign neg_q[0] = neg_ff[0];
   assign q_q[0]   = '0;

   for (genvar i = 0; i < QB; i++) begin : g_stage
      localparam int K = QB - 1 - i;
      logic [RD-1:0] sh;
      logic          take;

      assign sh   = RD'(den_q[i]) << K;
      assign take = rem_q[i] >= sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= take ? (rem_q[i] - sh) : rem_q[i];
            q_ff[i+1]   <= q_q[i] | (take ? (QB'(1) << K) : '0);
            neg_ff[i+1] <= neg_q[i];
         end
      end
      assign rem_q[i+1] = rem_ff[i+1];
      assign q_q[i+1]   = q_ff[i+1];
      assign neg_q[i+1] = neg_ff[i+1];

      if (i < QB - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[i+1] <= den_q[i];
            end
         end
         assign den_q[i+1] = den_ff[i+1];
      end
   end

   // Round the magnitude up for a negative quotient with a remainder.
   assign rem_nz = rem_q[QB] != '0;
   assign qx     = {1'b0, q_q[QB]} + (QB+1)'(neg_q[QB] && rem_nz);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_q[QB] ? (~qx + 1'b1) : qx;
      end
   end

   assign quo = quo_ff;
endmodule
`default_nettype wire

[rtl/core/ray_sphere_intersect_core.sv]
// Top level of the ray/sphere intersection core.
`default_nettype none
// Tests one ray per word against a sphere held in four write-only registers
// (center x/y/z and radius, fixed point). With o = origin - center and d = direction
// the core forms a = d.d, h = o.d, c = o.o - r*r and the quarter discriminant
// h*h - a*c, takes its integer square root s and tries the near root (-h - s)/a
// first; when that root is not ahead of the origin, or its hit point rounds onto
// the origin, the far root (-h + s)/a is used. A zero direction, a negative
// discriminant or no usable root gives hit = 0 with zero coordinates. Hit
// coordinates are origin + round(d*t) and saturate to the coordinate range. All
// products are exact, so the fraction position does not matter. The core takes
// one word per cycle while it is not stalled; its pipeline holds the square root
// (one stage per root bit), the six dividers (one stage per quotient bit) and
// three five-stage multiplier banks. Every stage moves on one advance signal that
// stalls only while a finished word waits in the output register, so no word is
// lost or repeated under back pressure. Write the registers only while the core
// is empty.
module ray_sphere_intersect_core #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit,
   output logic signed [COORD_WIDTH-1:0]      rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_hit_z,
   input  wire logic                          csr_we,
   input  wire rsi_pkg::csr_index_type        csr_index,
   input  wire logic [COORD_WIDTH-1:0]        csr_wdata
);
   import rsi_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int OW = W + 1;          // origin minus center
   localparam int AW = 2*W + 1;        // a = d.d, kept signed and non-negative
   localparam int HW = 2*W + 2;        // h = o.d
   localparam int CW = 2*W + 3;        // c = o.o - r*r
   localparam int DW = 4*W + 3;        // quarter discriminant
   localparam int XW = 4*W + 2;        // square root input
   localparam int RW = (XW + 1) / 2;   // square root
   localparam int NW = 2*W + 3;        // root numerators -h -/+ s
   localparam int MW = 2*W + 1;        // divisor 2a
   localparam int PW = 3*W + 4;        // dividend 2*d*n + a
   localparam int QB = W + 2;          // quotient magnitude bits
   localparam int FW = QB + 1;         // signed offset
   localparam int SW = W + 4;          // origin plus offset before saturation

   // ---------------- configuration registers ----------------
   logic signed [W-1:0] center_ff [3];
   logic [W-2:0]        radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= (W-1)'(RADIUS_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_ff[0] <= csr_wdata;
            CSR_CENTER_Y: center_ff[1] <= csr_wdata;
            CSR_CENTER_Z: center_ff[2] <= csr_wdata;
            CSR_RADIUS:   radius_ff    <= csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   // Advance everything unless a finished word is held at the output.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: offset from the center ----------------
   logic signed [W-1:0]  org_in [3];
   logic signed [W-1:0]  dir_in [3];
   logic                 v1_ff;
   logic signed [OW-1:0] o1_ff   [3];
   logic signed [W-1:0]  d1_ff   [3];
   logic signed [W-1:0]  org1_ff [3];

   assign org_in[0] = req_origin_x;
   assign org_in[1] = req_origin_y;
   assign org_in[2] = req_origin_z;
   assign dir_in[0] = req_dir_x;
   assign dir_in[1] = req_dir_y;
   assign dir_in[2] = req_dir_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            o1_ff[k]   <= OW'(org_in[k]) - OW'(center_ff[k]);
            d1_ff[k]   <= dir_in[k];
            org1_ff[k] <= org_in[k];
         end
      end
   end

   // ---------------- multiplier bank 1: dot products ----------------
   logic signed [2*W-1:0]  dd [3];
   logic signed [W+OW-1:0] od [3];
   logic signed [2*OW-1:0] oo [3];
   logic signed [2*W-1:0]  rr;

   for (genvar k = 0; k < 3; k++) begin : g_bank1
      rsi_mul #(.AW(W), .BW(W)) u_dd (
         .clock (clock), .en (adv), .a (d1_ff[k]), .b (d1_ff[k]), .p (dd[k])
      );
      rsi_mul #(.AW(OW), .BW(W)) u_od (
         .clock (clock), .en (adv), .a (o1_ff[k]), .b (d1_ff[k]), .p (od[k])
      );
      rsi_mul #(.AW(OW), .BW(OW)) u_oo (
         .clock (clock), .en (adv), .a (o1_ff[k]), .b (o1_ff[k]), .p (oo[k])
      );
   end

   rsi_mul #(.AW(W), .BW(W)) u_rr (
      .clock (clock), .en (adv), .a (signed'({1'b0, radius_ff})),
      .b (signed'({1'b0, radius_ff})), .p (rr)
   );

   localparam int D1W = 1 + 6*W;
   logic [D1W-1:0] d1_out;

   rsi_delay #(.WIDTH(D1W), .DEPTH(MUL_LAT)) u_dly1 (
      .clock (clock), .reset (reset), .en (adv),
      .din   ({v1_ff, org1_ff[0], org1_ff[1], org1_ff[2], d1_ff[0], d1_ff[1], d1_ff[2]}),
      .dout  (d1_out)
   );

   // ---------------- stage 2: sum a, h, c ----------------
   logic                 v2_ff;
   logic signed [AW-1:0] a2_ff;
   logic signed [HW-1:0] h2_ff;
   logic signed [CW-1:0] c2_ff;
   logic signed [W-1:0]  org2_ff [3];
   logic signed [W-1:0]  d2_ff   [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= d1_out[6*W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a2_ff <= AW'(dd[0]) + AW'(dd[1]) + AW'(dd[2]);
         h2_ff <= HW'(od[0]) + HW'(od[1]) + HW'(od[2]);
         c2_ff <= CW'(oo[0]) + CW'(oo[1]) + CW'(oo[2]) - CW'(rr);
         for (int k = 0; k < 3; k++) begin
            org2_ff[k] <= d1_out[(5-k)*W +: W];
            d2_ff[k]   <= d1_out[(2-k)*W +: W];
         end
      end
   end

   // ---------------- multiplier bank 2: h*h and a*c ----------------
   logic signed [2*HW-1:0]  hh;
   logic signed [AW+CW-1:0] ac;

   rsi_mul #(.AW(HW), .BW(HW)) u_hh (
      .clock (clock), .en (adv), .a (h2_ff), .b (h2_ff), .p (hh)
   );
   rsi_mul #(.AW(AW), .BW(CW)) u_ac (
      .clock (clock), .en (adv), .a (a2_ff), .b (c2_ff), .p (ac)
   );

   localparam int D2W = 1 + AW + HW + 6*W;
   logic [D2W-1:0] d2_out;

   rsi_delay #(.WIDTH(D2W), .DEPTH(MUL_LAT)) u_dly2 (
      .clock (clock), .reset (reset), .en (adv),
      .din   ({v2_ff, a2_ff, h2_ff, org2_ff[0], org2_ff[1], org2_ff[2],
               d2_ff[0], d2_ff[1], d2_ff[2]}),
      .dout  (d2_out)
   );

   // ---------------- stage 3: discriminant ----------------
   logic signed [AW-1:0] a2d;
   logic signed [DW-1:0] disc;
   logic                 v3_ff;
   logic                 miss3_ff;
   logic [XW-1:0]        rad3_ff;
   logic signed [AW-1:0] a3_ff;
   logic signed [HW-1:0] h3_ff;
   logic [6*W-1:0]       od3_ff;   // origin and direction, packed

   assign a2d  = d2_out[HW+6*W +: AW];
   assign disc = DW'(hh) - DW'(ac);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= d2_out[AW+HW+6*W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Drop a negative discriminant or a zero direction as a miss.
         miss3_ff <= disc[DW-1] || (a2d == '0);
         rad3_ff  <= disc[DW-1] ? '0 : disc[XW-1:0];
         a3_ff    <= a2d;
         h3_ff    <= d2_out[6*W +: HW];
         od3_ff   <= d2_out[6*W-1:0];
      end
   end

   // ---------------- square root ----------------
   logic [RW-1:0] s_root;

   rsi_sqrt #(.XW(XW)) u_sqrt (
      .clock (clock), .en (adv), .rad (rad3_ff), .root (s_root)
   );

   localparam int D3W = 2 + AW + HW + 6*W;
   logic [D3W-1:0] d3_out;

   rsi_delay #(.WIDTH(D3W), .DEPTH(RW)) u_dly3 (
      .clock (clock), .reset (reset), .en (adv),
      .din   ({v3_ff, miss3_ff, a3_ff, h3_ff, od3_ff}),
      .dout  (d3_out)
   );

   // ---------------- stage 4: root numerators ----------------
   logic signed [NW-1:0] hx;
   logic signed [NW-1:0] sx;
   logic                 v4_ff;
   logic                 miss4_ff;
   logic signed [AW-1:0] a4_ff;
   logic signed [NW-1:0] n4_ff   [2];
   logic signed [W-1:0]  org4_ff [3];
   logic signed [W-1:0]  d4_ff   [3];
   logic                 pos4    [2];

   assign hx = NW'(signed'(d3_out[6*W +: HW]));
   assign sx = signed'(NW'(s_root));

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= d3_out[1+AW+HW+6*W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         miss4_ff <= d3_out[AW+HW+6*W];
         a4_ff    <= d3_out[HW+6*W +: AW];
         n4_ff[0] <= -hx - sx;   // near root
         n4_ff[1] <= -hx + sx;   // far root
         for (int k = 0; k < 3; k++) begin
            org4_ff[k] <= d3_out[(5-k)*W +: W];
            d4_ff[k]   <= d3_out[(2-k)*W +: W];
         end
      end
   end

   // A root is ahead of the origin exactly when its numerator is positive.
   assign pos4[0] = !n4_ff[0][NW-1] && (n4_ff[0] != '0);
   assign pos4[1] = !n4_ff[1][NW-1] && (n4_ff[1] != '0);

   // ---------------- multiplier bank 3: d*n per root and axis ----------------
   logic signed [W+NW-1:0] dn [2][3];

   for (genvar j = 0; j < 2; j++) begin : g_root3
      for (genvar k = 0; k < 3; k++) begin : g_axis3
         rsi_mul #(.AW(W), .BW(NW)) u_dn (
            .clock (clock), .en (adv), .a (d4_ff[k]), .b (n4_ff[j]), .p (dn[j][k])
         );
      end
   end

   localparam int D4W = 4 + AW + 3*W;
   logic [D4W-1:0] d4_out;

   rsi_delay #(.WIDTH(D4W), .DEPTH(MUL_LAT)) u_dly4 (
      .clock (clock), .reset (reset), .en (adv),
      .din   ({v4_ff, miss4_ff, pos4[0], pos4[1], a4_ff,
               org4_ff[0], org4_ff[1], org4_ff[2]}),
      .dout  (d4_out)
   );

   // ---------------- stage 5: dividends ----------------
   logic signed [AW-1:0] a4d;
   logic                 v5_ff;
   logic [2:0]           flag5_ff;   // miss, near positive, far positive
   logic signed [PW-1:0] p5_ff [2][3];
   logic [MW-1:0]        den5_ff;
   logic [3*W-1:0]       org5_ff;

   assign a4d = d4_out[3*W +: AW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= d4_out[3+AW+3*W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flag5_ff <= d4_out[AW+3*W +: 3];
         den5_ff  <= {a4d[AW-2:0], 1'b0};
         org5_ff  <= d4_out[3*W-1:0];
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 3; k++) begin
               p5_ff[j][k] <= signed'({dn[j][k], 1'b0}) + PW'(a4d);
            end
         end
      end
   end

   // ---------------- dividers: rounded offsets ----------------
   logic signed [FW-1:0] off [2][3];

   for (genvar j = 0; j < 2; j++) begin : g_root5
      for (genvar k = 0; k < 3; k++) begin : g_axis5
         rsi_div #(.NW(PW), .MW(MW), .QB(QB)) u_div (
            .clock (clock), .en (adv), .num (p5_ff[j][k]), .den (den5_ff),
            .quo   (off[j][k])
         );
      end
   end

   localparam int D5W = 4 + 3*W;
   logic [D5W-1:0] d5_out;

   rsi_delay #(.WIDTH(D5W), .DEPTH(QB + 2)) u_dly5 (
      .clock (clock), .reset (reset), .en (adv),
      .din   ({v5_ff, flag5_ff, org5_ff}),
      .dout  (d5_out)
   );

   // ---------------- stage 6: root choice and hit point ----------------
   logic                 same [2];
   logic                 use_near;
   logic                 hit6_in;
   logic                 v6_ff;
   logic                 hit6_ff;
   logic signed [SW-1:0] sum6_ff [3];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         same[j] = (off[j][0] == '0) && (off[j][1] == '0) && (off[j][2] == '0);
      end
   end

   assign use_near = d5_out[3*W+1] && !same[0];
   assign hit6_in  = !d5_out[3*W+2] && (use_near || (d5_out[3*W] && !same[1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= d5_out[3*W+3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit6_ff <= hit6_in;
         for (int k = 0; k < 3; k++) begin
            sum6_ff[k] <= SW'(signed'(d5_out[(2-k)*W +: W]))
                        + SW'(use_near ? off[0][k] : off[1][k]);
         end
      end
   end

   // ---------------- output register: saturate ----------------
   logic signed [W-1:0] sat [3];
   logic                rsp_hit_ff;
   logic signed [W-1:0] rsp_coord_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if ((&sum6_ff[k][SW-1:W-1]) || !(|sum6_ff[k][SW-1:W-1])) begin
            sat[k] = sum6_ff[k][W-1:0];
         end else if (sum6_ff[k][SW-1]) begin
            sat[k] = {1'b1, {(W-1){1'b0}}};
         end else begin
            sat[k] = {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= hit6_ff;
         for (int k = 0; k < 3; k++) begin
            rsp_coord_ff[k] <= hit6_ff ? sat[k] : '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_coord_ff[0];
   assign rsp_hit_y = rsp_coord_ff[1];
   assign rsp_hit_z = rsp_coord_ff[2];
endmodule
`default_nettype wire

[rtl/core/rsi_check.sv]
// Port-level checks for the intersection core, bound to the top level.
`default_nettype none
module rsi_check #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_hit,
   input wire logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   input wire logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   input wire logic signed [COORD_WIDTH-1:0] rsp_hit_z
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_hit_x)
         && $stable(rsp_hit_y) && $stable(rsp_hit_z))
      else $error("result word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_hit_x == '0) && (rsp_hit_y == '0)
         && (rsp_hit_z == '0))
      else $error("miss word carries a nonzero point");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while the pipeline is stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind ray_sphere_intersect_core rsi_check #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_check (.*);
`default_nettype wire

[dv/ray_sphere_intersect_core_test.sv]
// Self-checking testbench for the ray/sphere intersection core.
module ray_sphere_intersect_core_test;
   import rsi_pkg::*;

   localparam int CW      = 32;
   localparam int ONE     = 65536;            // 1.0 in Q16.16
   localparam int DRAIN   = 200;              // settle time at the end of a drain
   localparam int STALL_LIMIT = 4000;         // cycles with no handshake at all

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct {
      logic                 hit;
      logic signed [CW-1:0] x, y, z;
   } hit_type;

   localparam logic signed [CW-1:0] SMAX = 32'sh7fffffff;
   localparam logic signed [CW-1:0] SMIN = 32'sh80000000;
   localparam wide_type SAT_HI = wide_type'(64'sd2147483647);
   localparam wide_type SAT_LO = -wide_type'(64'sd2147483648);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [CW-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic signed [CW-1:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic                 csr_we = 1'b0;
   csr_index_type        csr_index = CSR_CENTER_X;
   logic [CW-1:0]        csr_wdata = '0;

   ray_sphere_intersect_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sphere as the core should hold it.
   logic signed [CW-1:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
   logic [CW-2:0]        sph_r = 31'(RADIUS_RESET);

   hit_type hit_queue[$];
   int   fail_count = 0;
   int   rays_sent = 0;
   int   hits_seen = 0;
   int   misses_seen = 0;
   int   burst_left = 0;
   bit   gaps_on = 1'b1;
   bit   stalls_on = 1'b1;

   // Floor division by a positive divisor.
   function automatic wide_type floor_div(input wide_type p, input wide_type m);
      wide_type q;
      q = p / m;
      if ((p % m) != 0 && p < 0) q = q - 1;
      return q;
   endfunction

   function automatic wide_type isqrt(input wide_type x);
      logic [255:0] rem, res, one_bit;
      rem = x;
      res = '0;
      for (int k = 254; k >= 0; k -= 2) begin
         one_bit = 256'd1 << k;
         if (rem >= res + one_bit) begin
            rem = rem - (res + one_bit);
            res = (res >> 1) + one_bit;
         end else begin
            res = res >> 1;
         end
      end
      return wide_type'(res);
   endfunction

   // Hit offsets along the ray for numerator n; true when all land on the origin.
   function automatic bit hit_offsets(input wide_type d0, d1, d2, n, a,
                                      output wide_type f0, f1, f2);
      wide_type two_a;
      two_a = a + a;
      f0 = floor_div(2 * d0 * n + a, two_a);
      f1 = floor_div(2 * d1 * n + a, two_a);
      f2 = floor_div(2 * d2 * n + a, two_a);
      return f0 == 0 && f1 == 0 && f2 == 0;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(input wide_type p);
      if (p > SAT_HI) return SMAX;
      if (p < SAT_LO) return SMIN;
      return p[CW-1:0];
   endfunction

   function automatic hit_type trace_sphere(input ray_type r);
      hit_type  res;
      wide_type o0, o1, o2, d0, d1, d2, rr, a, h, c, disc, s, n, f0, f1, f2;
      bit       on_origin;
      res = '{1'b0, '0, '0, '0};
      o0 = wide_type'(r.ox) - wide_type'(sph_cx);
      o1 = wide_type'(r.oy) - wide_type'(sph_cy);
      o2 = wide_type'(r.oz) - wide_type'(sph_cz);
      d0 = wide_type'(r.dx);
      d1 = wide_type'(r.dy);
      d2 = wide_type'(r.dz);
      rr = wide_type'({225'd0, sph_r});
      a = d0 * d0 + d1 * d1 + d2 * d2;
      h = o0 * d0 + o1 * d1 + o2 * d2;
      c = o0 * o0 + o1 * o1 + o2 * o2 - rr * rr;
      if (a == 0) return res;
      disc = h * h - a * c;
      if (disc < 0) return res;
      s = isqrt(disc);
      // near root first, far root when near is behind or rounds onto the origin
      n = -h - s;
      on_origin = hit_offsets(d0, d1, d2, n, a, f0, f1, f2);
      if (n <= 0 || on_origin) begin
         n = -h + s;
         on_origin = hit_offsets(d0, d1, d2, n, a, f0, f1, f2);
      end
      if (n <= 0 || on_origin) return res;
      res.hit = 1'b1;
      res.x = clamp_coord(wide_type'(r.ox) + f0);
      res.y = clamp_coord(wide_type'(r.oy) + f1);
      res.z = clamp_coord(wide_type'(r.oz) + f2);
      return res;
   endfunction

   // Receiver: random stall runs, or always ready.
   int stall_run = 0;
   always @(posedge clock) begin
      if (!stalls_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_run <= $urandom_range(1, 12);
      end
   end

   // Compare every accepted result word against the oldest expectation.
   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_queue.size() == 0) begin
            $error("unexpected result word: hit=%0b", rsp_hit);
            fail_count++;
         end else begin
            want = hit_queue.pop_front();
            if (rsp_hit) hits_seen++; else misses_seen++;
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_hit_x !== want.x) begin
               $error("hit_x: expected %0d, got %0d", want.x, rsp_hit_x);
               fail_count++;
            end
            if (rsp_hit_y !== want.y) begin
               $error("hit_y: expected %0d, got %0d", want.y, rsp_hit_y);
               fail_count++;
            end
            if (rsp_hit_z !== want.z) begin
               $error("hit_z: expected %0d, got %0d", want.z, rsp_hit_z);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Load all four sphere registers on back-to-back edges, then drop the enable.
   task automatic set_sphere(input logic signed [CW-1:0] cx, cy, cz,
                             input logic [CW-2:0] r);
      csr_we <= 1'b1; csr_index <= CSR_CENTER_X; csr_wdata <= cx;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y; csr_wdata <= cy;
      @(posedge clock);
      csr_index <= CSR_CENTER_Z; csr_wdata <= cz;
      @(posedge clock);
      csr_index <= CSR_RADIUS; csr_wdata <= {1'b0, r};
      @(posedge clock);
      csr_we <= 1'b0;
      sph_cx = cx; sph_cy = cy; sph_cz = cz; sph_r = r;
      @(posedge clock);
   endtask

   // Send one ray word; hold valid and payload until the core takes it.
   task automatic send_ray(input ray_type r);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
      req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
      do @(posedge clock); while (!req_ready);
      hit_queue.push_back(trace_sphere(r));
      rays_sent++;
   endtask

   // Hold off the sender until every result is back, then let the pipe settle.
   task automatic drain_core();
      req_valid <= 1'b0;
      burst_left = 0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic send6(input logic signed [CW-1:0] ox, oy, oz, dx, dy, dz);
      ray_type r;
      r = '{ox, oy, oz, dx, dy, dz};
      send_ray(r);
   endtask

   function automatic logic signed [CW-1:0] jitter(input int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // Ray aimed near the sphere center, starting a few radii away or inside.
   function automatic ray_type aimed_ray();
      ray_type r;
      int      reach;
      reach = (sph_r > 31'd4194304 || sph_r == 0) ? 4 * ONE : 4 * int'(sph_r) + 16;
      r.ox = sph_cx + jitter(reach);
      r.oy = sph_cy + jitter(reach);
      r.oz = sph_cz + jitter(reach);
      r.dx = (sph_cx - r.ox) + jitter(reach / 4 + 1);
      r.dy = (sph_cy - r.oy) + jitter(reach / 4 + 1);
      r.dz = (sph_cz - r.oz) + jitter(reach / 4 + 1);
      if ($urandom_range(0, 4) == 0) begin
         // shrink the direction to exercise tiny steps and rounding
         r.dx = r.dx >>> $urandom_range(0, 20);
         r.dy = r.dy >>> $urandom_range(0, 20);
         r.dz = r.dz >>> $urandom_range(0, 20);
      end
      return r;
   endfunction

   function automatic ray_type noise_ray();
      ray_type r;
      r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         r.dx = '0; r.dy = '0; r.dz = '0;
      end
      return r;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) send_ray(noise_ray());
         else send_ray(aimed_ray());
      end
   endtask

   // Unit sphere at the origin: through, from inside, from the surface, tangent, behind.
   task automatic test_unit_sphere();
      send6(0, 0, -5 * ONE, 0, 0, ONE);
      send6(0, 0, 0, ONE, 0, 0);
      send6(0, 0, -ONE, 0, 0, ONE);
      send6(0, 0, -ONE, 0, 0, -ONE);
      send6(0, 0, 0, 0, 0, 0);
      send6(0, 0, 5 * ONE, 0, 0, ONE);
      send6(ONE, 0, -5 * ONE, 0, 0, ONE);
      send6(2 * ONE, 0, -5 * ONE, 0, 0, ONE);
      send6(-5 * ONE, 0, 0, 1, 0, 0);
      send6(-5 * ONE, 3, -7, 1, 0, 0);
      send6(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
      send6(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
      send6(SMIN, 0, 0, SMAX, 0, 0);
      send6(-1, -1, -1, 1, 1, 1);
      drain_core();
   endtask

   // Extreme spheres: hit points that saturate high and low, zero radius.
   task automatic test_extreme_spheres();
      set_sphere(SMAX, SMAX, SMAX, 31'h7fffffff);
      send6(SMAX, SMAX, SMAX, 1, 1, 1);
      send6(SMAX, SMAX, SMAX, -1, 0, 0);
      send6(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
      drain_core();
      set_sphere(SMIN, SMIN, SMIN, 31'h7fffffff);
      send6(SMIN, SMIN, SMIN, -1, -1, -1);
      send6(SMIN, SMIN, SMIN, SMAX, 0, 0);
      drain_core();
      set_sphere(0, 0, 0, 31'd0);
      send6(-ONE, 0, 0, ONE, 0, 0);
      send6(0, 0, -ONE, 0, 0, 1);
      drain_core();
   endtask

   task automatic test_random_spheres();
      set_sphere(0, 0, 0, 31'(ONE));
      run_random(275);
      drain_core();
      set_sphere(jitter(64 * ONE), jitter(64 * ONE), jitter(64 * ONE),
                 31'($urandom_range(1, 16 * ONE)));
      run_random(275);
      drain_core();
      set_sphere(jitter(ONE), jitter(ONE), jitter(ONE), 31'($urandom_range(0, 64)));
      run_random(275);
      drain_core();
      // back-to-back words, receiver always ready
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      set_sphere($urandom, $urandom, $urandom, 31'($urandom));
      run_random(275);
      drain_core();
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      set_sphere(SMAX - 8 * ONE, SMIN + 8 * ONE, 0, 31'(2 * ONE));
      run_random(275);
      drain_core();
      set_sphere(jitter(1024 * ONE), jitter(1024 * ONE), jitter(1024 * ONE),
                 31'($urandom_range(ONE, 512 * ONE)));
      run_random(275);
      drain_core();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unit_sphere();
      test_extreme_spheres();
      test_random_spheres();
      $display("Sent %0d rays over ten sphere settings, extremes included.", rays_sent);
      $display("Results checked: %0d hits, %0d misses.", hits_seen, misses_seen);
      if (fail_count == 0 && hit_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[ray_sphere_intersect_core.f]
rtl/core/rsi_pkg.sv
rtl/core/rsi_delay.sv
rtl/core/rsi_mul.sv
rtl/core/rsi_sqrt.sv
rtl/core/rsi_div.sv
rtl/core/ray_sphere_intersect_core.sv
rtl/core/rsi_check.sv
dv/ray_sphere_intersect_core_test.sv
